FILE: design/clsr_pkg.sv
// Shared types, constants and helpers for the crossfade loop sample reader.
// Used by the controller, the datapath and the top level; depends on nothing.
package clsr_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int MIN_LOOP_FRAMES   = 4100;
    localparam int DEF_MEMORY_FRAMES = 65536;

    localparam int POS_W       = 17;
    localparam int IN_ADDR_W   = 16;
    localparam int IN_SAMPLE_W = 16;
    localparam int XL_W        = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    localparam int GAIN_FRAC_BITS = 15;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int COEF_W         = GAIN_W + 1;
    localparam int PROD_W         = SAMPLE_BITS + COEF_W;
    localparam int ACC_W          = PROD_W + 1;
    localparam int NUM_W          = POS_W + 2;
    localparam int DEN_W          = XL_W + 1;
    localparam int DIV_CNT_W      = $clog2(GAIN_FRAC_BITS);
    localparam int MUL_TERMS      = 4;
    localparam int MUL_CNT_W      = $clog2(MUL_TERMS + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_LOOP_START  = 3'd0;
    localparam cfg_index_t REG_LOOP_END    = 3'd1;
    localparam cfg_index_t REG_FRAME_COUNT = 3'd2;
    localparam cfg_index_t REG_STEREO_MODE = 3'd3;
    localparam cfg_index_t REG_XFADE_LEN   = 3'd4;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                        opcode;
        logic [IN_ADDR_W-1:0]           write_address;
        logic signed [IN_SAMPLE_W-1:0]  write_left;
        logic signed [IN_SAMPLE_W-1:0]  write_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          in_crossfade;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_CLAMP,
        ST_CALC,
        ST_READ_PRE,
        ST_READ_CAP,
        ST_GAIN,
        ST_DIV,
        ST_MUL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic mem_write;
        logic norm;
        logic clamp;
        logic calc;
        logic read_pre;
        logic capture_pre;
        logic gain;
        logic div_step;
        logic mul_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_step;
        logic silent;
        logic div_needed;
        logic div_last;
        logic mul_last;
        logic out_free;
    } dp_status_t;

    // Round half up, drop the gain fraction and saturate to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        localparam int Q_W = ACC_W + 1 - GAIN_FRAC_BITS;
        logic signed [ACC_W:0]  biased;
        logic signed [Q_W-1:0]  q;
        logic signed [Q_W-1:0]  max_v;
        logic signed [Q_W-1:0]  min_v;
        biased = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(1 << (GAIN_FRAC_BITS - 1)));
        q      = $signed(biased[ACC_W:GAIN_FRAC_BITS]);
        max_v  = $signed(Q_W'((1 << (SAMPLE_BITS - 1)) - 1));
        min_v  = $signed(Q_W'(-(1 << (SAMPLE_BITS - 1))));
        if (q > max_v) begin
            return max_v[SAMPLE_BITS-1:0];
        end else if (q < min_v) begin
            return min_v[SAMPLE_BITS-1:0];
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: design/clsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module clsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/clsr_ctrl.sv
// Sequencing state machine for the crossfade loop sample reader.
// Depends on clsr_pkg; drives datapath commands from datapath status.
module clsr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clsr_pkg::dp_status_t  sts,
    output clsr_pkg::ctrl_cmd_t   cmd
);
    import clsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.op_step) begin
                        state_next = ST_NORM;
                    end else begin
                        cmd.mem_write = 1'b1;
                    end
                end
            end
            ST_NORM: begin
                cmd.norm   = 1'b1;
                state_next = sts.silent ? ST_FINISH : ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_READ_PRE;
            end
            ST_READ_PRE: begin
                cmd.read_pre = 1'b1;
                state_next   = ST_READ_CAP;
            end
            ST_READ_CAP: begin
                cmd.capture_pre = 1'b1;
                state_next      = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = sts.div_needed ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/clsr_datapath.sv
// Datapath: configuration registers, sample memories, loop arithmetic,
// serial gain divider, shared blend multiplier and output register. Uses clsr_pkg, clsr_ram.
module clsr_datapath #(
    parameter int MEMORY_FRAMES = clsr_pkg::DEF_MEMORY_FRAMES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  clsr_pkg::in_item_t                  s_data,
    input  clsr_pkg::ctrl_cmd_t                 cmd,
    output clsr_pkg::dp_status_t                sts,
    input  logic                                cfg_valid,
    input  clsr_pkg::cfg_index_t                cfg_index,
    input  logic [clsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output clsr_pkg::out_item_t                 m_data
);
    import clsr_pkg::*;

    localparam int ADDR_W = $clog2(MEMORY_FRAMES);

    // configuration
    logic [XL_W-1:0]  loop_start_reg;
    logic [POS_W-1:0] loop_end_reg;
    logic [POS_W-1:0] frame_count_reg;
    logic             stereo_reg;
    logic [XL_W-1:0]  xfade_len_reg;

    // control state
    logic [POS_W-1:0]     play_pos_reg,  play_pos_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,   div_cnt_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg,   mul_cnt_next;
    logic                 m_valid_reg,   m_valid_next;

    // payload
    logic [POS_W-1:0]              start_reg,   start_next;
    logic [POS_W-1:0]              end_reg,     end_next;
    logic [POS_W-1:0]              cur_pos_reg, cur_pos_next;
    logic                          cf_reg,      cf_next;
    logic                          use_s1_reg,  use_s1_next;
    logic signed [NUM_W-1:0]       num_reg,     num_next;
    logic signed [DEN_W-1:0]       den_reg,     den_next;
    logic [POS_W-1:0]              pre_reg,     pre_next;
    logic [GAIN_W-1:0]             gain_reg,    gain_next;
    logic [GAIN_W-1:0]             rem_reg,     rem_next;
    logic [GAIN_FRAC_BITS-1:0]     quot_reg,    quot_next;
    logic signed [SAMPLE_BITS-1:0] s0l_reg, s0l_next, s0r_reg, s0r_next;
    logic signed [SAMPLE_BITS-1:0] s1l_reg, s1l_next, s1r_reg, s1r_next;
    logic signed [PROD_W-1:0]      prod_reg,    prod_next;
    logic signed [ACC_W-1:0]       acc_l_reg,   acc_l_next;
    logic signed [ACC_W-1:0]       acc_r_reg,   acc_r_next;
    out_item_t                     m_data_reg,  m_data_next;

    // memories
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   rd_en;
    logic [POS_W-1:0]       rd_idx;
    logic [SAMPLE_BITS-1:0] left_rd, right_rd;

    // combinational helpers
    logic [POS_W-1:0]          ls, s_sw, e_sw;
    logic                      swap;
    logic [POS_W:0]            e_wide;
    logic [POS_W:0]            cf_sum;
    logic signed [NUM_W-1:0]   num_calc, pre_calc;
    logic signed [DEN_W-1:0]   den_calc;
    logic                      num_pos, den_pos, num_ge_den;
    logic [GAIN_W:0]           trial;
    logic                      trial_ge;
    logic [GAIN_W-1:0]         rem_step;
    logic [GAIN_FRAC_BITS-1:0] quot_step;
    logic signed [SAMPLE_BITS-1:0] op_a;
    logic signed [COEF_W-1:0]      op_b;
    logic signed [COEF_W-1:0]      coef_g, coef_gc;
    logic signed [PROD_W-1:0]      prod_calc;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [SAMPLE_BITS-1:0] l_res, r_res;
    logic [POS_W:0]                pos_inc;
    logic                          pos_ok, pre_ok;

    assign wr_addr = ADDR_W'(s_data.write_address);
    assign wr_en   = cmd.mem_write
                   && (32'(s_data.write_address) < 32'(MEMORY_FRAMES));
    assign rd_en   = cmd.calc | cmd.read_pre;
    assign rd_idx  = cmd.read_pre ? pre_reg : cur_pos_reg;
    assign pos_ok  = 32'(cur_pos_reg) < 32'(MEMORY_FRAMES);
    assign pre_ok  = 32'(pre_reg) < 32'(MEMORY_FRAMES);

    clsr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MEMORY_FRAMES)) u_left_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (SAMPLE_BITS'($unsigned(s_data.write_left))),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(rd_idx)),
        .rd_data (left_rd)
    );

    clsr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MEMORY_FRAMES)) u_right_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (SAMPLE_BITS'($unsigned(s_data.write_right))),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(rd_idx)),
        .rd_data (right_rd)
    );

    // loop bounds: order, widen an empty loop, pull back past the file end
    assign ls     = {1'b0, loop_start_reg};
    assign swap   = ls > loop_end_reg;
    assign s_sw   = swap ? loop_end_reg : ls;
    assign e_sw   = swap ? ls : loop_end_reg;
    assign e_wide = {1'b0, e_sw} + (POS_W + 1)'(MIN_LOOP_FRAMES);

    // crossfade region, gain numerator and denominator, pre-loop index
    assign cf_sum   = {1'b0, cur_pos_reg} + (POS_W + 1)'(xfade_len_reg);
    assign num_calc = $signed(NUM_W'(end_reg)) - $signed(NUM_W'(cur_pos_reg))
                    - $signed(NUM_W'(1));
    assign den_calc = $signed(DEN_W'(xfade_len_reg)) - $signed(DEN_W'(1));
    assign pre_calc = $signed(NUM_W'(start_reg)) + $signed(NUM_W'(cur_pos_reg))
                    - $signed(NUM_W'(end_reg));

    assign num_pos    = !num_reg[NUM_W-1] && (num_reg != '0);
    assign den_pos    = !den_reg[DEN_W-1] && (den_reg != '0);
    assign num_ge_den = num_reg >= NUM_W'(den_reg);

    // one restoring step of the gain division
    assign trial     = {rem_reg, 1'b0};
    assign trial_ge  = trial >= {1'b0, den_reg[GAIN_W-1:0]};
    assign rem_step  = trial_ge ? GAIN_W'(trial - {1'b0, den_reg[GAIN_W-1:0]})
                                : trial[GAIN_W-1:0];
    assign quot_step = {quot_reg[GAIN_FRAC_BITS-2:0], trial_ge};

    // shared multiplier: left s0, left s1, right s0, right s1
    assign coef_g  = $signed({1'b0, gain_reg});
    assign coef_gc = $signed({1'b0, GAIN_W'(GAIN_ONE - gain_reg)});
    always_comb begin
        case (mul_cnt_reg[1:0])
            2'd0:    begin op_a = s0l_reg; op_b = coef_g;  end
            2'd1:    begin op_a = s1l_reg; op_b = coef_gc; end
            2'd2:    begin op_a = s0r_reg; op_b = coef_g;  end
            default: begin op_a = s1r_reg; op_b = coef_gc; end
        endcase
    end
    assign prod_calc = op_a * op_b;
    assign prod_ext  = ACC_W'(prod_reg);

    assign l_res   = round_sat(acc_l_reg);
    assign r_res   = stereo_reg ? round_sat(acc_r_reg) : l_res;
    assign pos_inc = {1'b0, cur_pos_reg} + (POS_W + 1)'(1);

    always_comb begin
        play_pos_next = play_pos_reg;
        div_cnt_next  = div_cnt_reg;
        mul_cnt_next  = mul_cnt_reg;
        m_valid_next  = m_valid_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        cur_pos_next  = cur_pos_reg;
        cf_next       = cf_reg;
        use_s1_next   = use_s1_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        pre_next      = pre_reg;
        gain_next     = gain_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        s0l_next      = s0l_reg;
        s0r_next      = s0r_reg;
        s1l_next      = s1l_reg;
        s1r_next      = s1r_reg;
        prod_next     = prod_reg;
        acc_l_next    = acc_l_reg;
        acc_r_next    = acc_r_reg;
        m_data_next   = m_data_reg;

        if (cmd.norm) begin
            start_next = s_sw;
            end_next   = e_sw;
            if (s_sw == e_sw) begin
                if (e_wide >= {1'b0, frame_count_reg}) begin
                    start_next = (frame_count_reg >= POS_W'(MIN_LOOP_FRAMES))
                               ? POS_W'(frame_count_reg - POS_W'(MIN_LOOP_FRAMES))
                               : '0;
                    end_next   = POS_W'(frame_count_reg - POS_W'(1));
                end else begin
                    end_next = e_wide[POS_W-1:0];
                end
            end
        end

        if (cmd.clamp) begin
            cur_pos_next = ((play_pos_reg < start_reg) || (play_pos_reg >= end_reg))
                         ? start_reg : play_pos_reg;
        end

        if (cmd.calc) begin
            cf_next     = cf_sum >= {1'b0, end_reg};
            num_next    = num_calc;
            den_next    = den_calc;
            pre_next    = pre_calc[POS_W-1:0];
            use_s1_next = (cf_sum >= {1'b0, end_reg}) && !pre_calc[NUM_W-1];
        end

        if (cmd.read_pre) begin
            s0l_next = pos_ok ? $signed(left_rd) : '0;
            s0r_next = pos_ok ? $signed(right_rd) : '0;
        end

        if (cmd.capture_pre) begin
            s1l_next = (use_s1_reg && pre_ok) ? $signed(left_rd) : '0;
            s1r_next = (use_s1_reg && pre_ok) ? $signed(right_rd) : '0;
        end

        if (cmd.gain) begin
            mul_cnt_next = '0;
            div_cnt_next = '0;
            rem_next     = num_reg[GAIN_W-1:0];
            quot_next    = '0;
            if (!cf_reg) begin
                gain_next = GAIN_ONE;
            end else if (!den_pos) begin
                gain_next = num_pos ? GAIN_ONE : '0;
            end else if (!num_pos) begin
                gain_next = '0;
            end else if (num_ge_den) begin
                gain_next = GAIN_ONE;
            end
        end

        if (cmd.div_step) begin
            rem_next     = rem_step;
            quot_next    = quot_step;
            div_cnt_next = DIV_CNT_W'(div_cnt_reg + DIV_CNT_W'(1));
            if (sts.div_last) begin
                gain_next = {1'b0, quot_step};
            end
        end

        if (cmd.mul_step) begin
            prod_next    = prod_calc;
            mul_cnt_next = MUL_CNT_W'(mul_cnt_reg + MUL_CNT_W'(1));
            // accumulate the product issued in the previous cycle
            case (mul_cnt_reg)
                MUL_CNT_W'(1): acc_l_next = prod_ext;
                MUL_CNT_W'(2): acc_l_next = acc_l_reg + prod_ext;
                MUL_CNT_W'(3): acc_r_next = prod_ext;
                MUL_CNT_W'(4): acc_r_next = acc_r_reg + prod_ext;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
            if (sts.silent) begin
                m_data_next = '0;
            end else begin
                m_data_next.left_out     = l_res;
                m_data_next.right_out    = r_res;
                m_data_next.in_crossfade = cf_reg;
                play_pos_next = (pos_inc >= {1'b0, end_reg})
                              ? start_reg : pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_start_reg  <= '0;
            loop_end_reg    <= POS_W'(65536);
            frame_count_reg <= '0;
            stereo_reg      <= 1'b1;
            xfade_len_reg   <= XL_W'(2048);
            play_pos_reg    <= '0;
            div_cnt_reg     <= '0;
            mul_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_LOOP_START:  loop_start_reg  <= cfg_data[XL_W-1:0];
                    REG_LOOP_END:    loop_end_reg    <= cfg_data[POS_W-1:0];
                    REG_FRAME_COUNT: frame_count_reg <= cfg_data[POS_W-1:0];
                    REG_STEREO_MODE: stereo_reg      <= cfg_data[0];
                    REG_XFADE_LEN:   xfade_len_reg   <= cfg_data[XL_W-1:0];
                    default: ;
                endcase
            end
            play_pos_reg <= play_pos_next;
            div_cnt_reg  <= div_cnt_next;
            mul_cnt_reg  <= mul_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg   <= start_next;
        end_reg     <= end_next;
        cur_pos_reg <= cur_pos_next;
        cf_reg      <= cf_next;
        use_s1_reg  <= use_s1_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        pre_reg     <= pre_next;
        gain_reg    <= gain_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        s0l_reg     <= s0l_next;
        s0r_reg     <= s0r_next;
        s1l_reg     <= s1l_next;
        s1r_reg     <= s1r_next;
        prod_reg    <= prod_next;
        acc_l_reg   <= acc_l_next;
        acc_r_reg   <= acc_r_next;
        m_data_reg  <= m_data_next;
    end

    assign sts.op_step    = (s_data.opcode == OP_STEP);
    assign sts.silent     = (frame_count_reg == '0);
    assign sts.div_needed = cf_reg && den_pos && num_pos && !num_ge_den;
    assign sts.div_last   = (div_cnt_reg == DIV_CNT_W'(GAIN_FRAC_BITS - 1));
    assign sts.mul_last   = (mul_cnt_reg == MUL_CNT_W'(MUL_TERMS));
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: design/crossfade_loop_sample_reader.sv
// Crossfading loop sample reader: a write item (opcode 0) stores one stereo frame into the
// left and right sample memories, and write items can follow each other every cycle while
// no step item is in flight. A step item (opcode 1) yields one output frame: it is taken one
// at a time and holds the input closed until its frame is loaded into the output register.
// The serial divider adds 15 restoring steps, one quotient bit a cycle, when the crossfade
// gain needs it; a zero frame count skips the loop arithmetic and gives a zero frame. The
// step work is the loop arithmetic, two reads of the registered memory port, the divider
// and four passes through one shared multiplier. The finished frame waits in an output
// register, so write and step items are taken while it waits to be collected. Sample memories
// start undefined; configure with cfg_index/cfg_data while no step item is in flight.
// Depends on clsr_pkg, clsr_ctrl, clsr_datapath and clsr_ram.
module crossfade_loop_sample_reader #(
    parameter int MEMORY_FRAMES = clsr_pkg::DEF_MEMORY_FRAMES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  clsr_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output clsr_pkg::out_item_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  clsr_pkg::cfg_index_t             cfg_index,
    input  logic [clsr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import clsr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    clsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    clsr_datapath #(.MEMORY_FRAMES(MEMORY_FRAMES)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a new frame is loaded only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("output frame loaded over an uncollected one");

    // a step item keeps the input closed on the next cycle
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.opcode == OP_STEP) |=> !s_ready)
        else $error("input reopened right after a step item");

    // output valid rises only from a controller load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.load_out))
        else $error("output valid raised without a load");

    // no memory write while a step item is being worked
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_write |-> (s_ready && !(cmd.div_step || cmd.mul_step)))
        else $error("memory written outside idle");

endmodule

FILE: tb/tb_crossfade_loop_sample_reader.sv
// Self-checking bench for the crossfading loop sample reader: drives write and step items
// with random idling, predicts every output frame and compares the fields it can predict.
// Depends on clsr_pkg and crossfade_loop_sample_reader.
module tb_crossfade_loop_sample_reader;
    timeunit 1ns;
    timeprecision 1ps;

    import clsr_pkg::*;

    localparam int     MEM_FRAMES   = DEF_MEMORY_FRAMES;
    localparam int     MEM_AW       = $clog2(MEM_FRAMES);
    localparam int     DRAIN_CYCLES = 40;
    localparam longint UNITY_GAIN   = longint'(1) << GAIN_FRAC_BITS;
    localparam longint SAMPLE_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;
    localparam logic signed [IN_SAMPLE_W-1:0] PEAK_HI = {1'b0, {(IN_SAMPLE_W-1){1'b1}}};
    localparam logic signed [IN_SAMPLE_W-1:0] PEAK_LO = {1'b1, {(IN_SAMPLE_W-1){1'b0}}};

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = REG_LOOP_START;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the block state
    logic signed [SAMPLE_BITS-1:0] left_mem  [MEM_FRAMES];
    logic signed [SAMPLE_BITS-1:0] right_mem [MEM_FRAMES];
    bit                            written   [MEM_FRAMES];
    logic [POS_W-1:0]              play_pos    = '0;
    logic [15:0]                   loop_start  = '0;
    logic [16:0]                   loop_end    = 17'h10000;
    logic [16:0]                   frame_total = '0;
    logic                          stereo_on   = 1'b1;
    logic [XL_W-1:0]               fade_len    = XL_W'(2048);

    // Frames that read an unwritten entry have only their crossfade flag checked
    out_item_t expected_frames [$];
    bit        expected_known  [$];
    out_item_t want_frame;
    bit        want_known;
    int        mismatches = 0;
    int        gap_pct    = 0;
    int        stall_pct  = 0;
    int        stall_left = 0;

    crossfade_loop_sample_reader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint fetch(input logic right_side, input longint idx);
        logic [MEM_AW-1:0] a;
        if (idx < 0 || idx >= MEM_FRAMES) begin
            return 0;
        end
        a = idx[MEM_AW-1:0];
        return right_side ? longint'(right_mem[a]) : longint'(left_mem[a]);
    endfunction

    // An entry outside the memory reads as zero; inside it must have been written.
    function automatic bit entry_known(input longint idx);
        if (idx < 0 || idx >= MEM_FRAMES) begin
            return 1'b1;
        end
        return written[idx[MEM_AW-1:0]];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] mix_sample(
        input longint cur, input longint early, input longint gain, input logic take_pre
    );
        longint acc;
        acc = cur * gain + (take_pre ? early * (UNITY_GAIN - gain) : 0);
        acc = (acc + (UNITY_GAIN >>> 1)) >>> GAIN_FRAC_BITS;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
        end else if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
        end
        return acc[SAMPLE_BITS-1:0];
    endfunction

    // Work out the frame for one step item and advance the play position.
    function automatic out_item_t play_next_frame(output bit known);
        out_item_t res;
        longint    lo, hi, fc, pos, xl, num, den, gain, pre, tmp;
        logic      fade, take_pre;
        res   = '0;
        known = 1'b1;
        if (frame_total == 0) begin
            return res;
        end
        lo = loop_start;
        hi = loop_end;
        fc = frame_total;
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        if (lo == hi) begin
            hi += MIN_LOOP_FRAMES;
            if (hi >= fc) begin
                lo = fc - MIN_LOOP_FRAMES;
                hi = fc - 1;
                if (lo < 0) begin
                    lo = 0;
                end
            end
        end
        pos = play_pos;
        if (pos < lo || pos >= hi) begin
            pos = lo;
        end
        xl       = fade_len;
        gain     = UNITY_GAIN;
        pre      = 0;
        take_pre = 1'b0;
        fade     = (pos >= hi - xl);
        if (fade) begin
            num = hi - 1 - pos;
            den = xl - 1;
            if (den <= 0) begin
                gain = (num > 0) ? UNITY_GAIN : 0;
            end else if (num <= 0) begin
                gain = 0;
            end else if (num >= den) begin
                gain = UNITY_GAIN;
            end else begin
                gain = (num * UNITY_GAIN) / den;
            end
            pre      = lo - (hi - pos);
            take_pre = (pre >= 0);
        end
        known = entry_known(pos) && (!take_pre || entry_known(pre));
        res.left_out = mix_sample(fetch(1'b0, pos), fetch(1'b0, pre), gain, take_pre);
        if (stereo_on) begin
            res.right_out = mix_sample(fetch(1'b1, pos), fetch(1'b1, pre), gain, take_pre);
        end else begin
            res.right_out = res.left_out;
        end
        res.in_crossfade = fade;
        pos += 1;
        if (pos >= hi) begin
            pos = lo;
        end
        play_pos = pos[POS_W-1:0];
        return res;
    endfunction

    function automatic logic signed [IN_SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                return PEAK_HI;
            end
            1: begin
                return PEAK_LO;
            end
            default: begin
                return IN_SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    // Drive one item and hold it until taken; valid stays up for a following item.
    task automatic send_item(input in_item_t item);
        out_item_t frame;
        bit        known;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (item.opcode == OP_STEP) begin
            frame           = play_next_frame(known);
            expected_frames = {expected_frames, frame};
            expected_known  = {expected_known, known};
        end else begin
            left_mem[item.write_address]  = item.write_left;
            right_mem[item.write_address] = item.write_right;
            written[item.write_address]   = 1'b1;
        end
    endtask

    task automatic write_frame(
        input logic [IN_ADDR_W-1:0] addr,
        input logic signed [IN_SAMPLE_W-1:0] l,
        input logic signed [IN_SAMPLE_W-1:0] r
    );
        in_item_t item;
        item.opcode        = OP_WRITE;
        item.write_address = addr;
        item.write_left    = l;
        item.write_right   = r;
        send_item(item);
    endtask

    // Unused fields of a step item carry random bits.
    task automatic step_frames(input int n);
        in_item_t item;
        repeat (n) begin
            item.opcode        = OP_STEP;
            item.write_address = IN_ADDR_W'($urandom);
            item.write_left    = IN_SAMPLE_W'($urandom);
            item.write_right   = IN_SAMPLE_W'($urandom);
            send_item(item);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_LOOP_START: begin
                loop_start = value[15:0];
            end
            REG_LOOP_END: begin
                loop_end = value[16:0];
            end
            REG_FRAME_COUNT: begin
                frame_total = value[16:0];
            end
            REG_STEREO_MODE: begin
                stereo_on = value[0];
            end
            REG_XFADE_LEN: begin
                fade_len = value[XL_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(
        input logic [CFG_DATA_W-1:0] from_pos,
        input logic [CFG_DATA_W-1:0] to_pos,
        input logic [CFG_DATA_W-1:0] frames,
        input logic                  two_ch,
        input logic [CFG_DATA_W-1:0] fade
    );
        settle();
        write_reg(REG_LOOP_START, from_pos);
        write_reg(REG_LOOP_END, to_pos);
        write_reg(REG_FRAME_COUNT, frames);
        write_reg(REG_STEREO_MODE, CFG_DATA_W'(two_ch) | (CFG_DATA_W'($urandom) & ~17'd1));
        write_reg(REG_XFADE_LEN, fade);
    endtask

    task automatic pick_settings();
        int unsigned           span, base;
        logic [CFG_DATA_W-1:0] a, b, n, x;
        n = CFG_DATA_W'(MEM_FRAMES);
        case ($urandom_range(0, 3))
            0: begin
                // short loop, so that steps reach the crossfade and the wrap
                span = $urandom_range(2, 200);
                base = $urandom_range(0, MEM_FRAMES - span);
                a    = CFG_DATA_W'(base);
                b    = CFG_DATA_W'(base + span);
                if ($urandom_range(0, 1) == 1 && b < MEM_FRAMES) begin
                    a = CFG_DATA_W'(base + span);
                    b = CFG_DATA_W'(base);
                end
                x = CFG_DATA_W'($urandom_range(0, span + 4));
                if ($urandom_range(0, 3) == 0) begin
                    n = CFG_DATA_W'($urandom_range(1, MEM_FRAMES));
                end
            end
            1: begin
                a = CFG_DATA_W'($urandom_range(0, MEM_FRAMES - 1));
                b = a;
                n = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 8000)
                                                      : $urandom_range(1, MEM_FRAMES));
                x = CFG_DATA_W'($urandom_range(0, 8000));
            end
            2: begin
                a = CFG_DATA_W'($urandom);
                b = CFG_DATA_W'($urandom);
                n = CFG_DATA_W'($urandom);
                x = CFG_DATA_W'($urandom);
            end
            default: begin
                a = $urandom_range(0, 1) ? CFG_DATA_W'(MEM_FRAMES - 1) : '0;
                b = $urandom_range(0, 1) ? CFG_DATA_W'(MEM_FRAMES) : '0;
                case ($urandom_range(0, 3))
                    0: n = '0;
                    1: n = CFG_DATA_W'(1);
                    default: n = CFG_DATA_W'(MEM_FRAMES);
                endcase
                case ($urandom_range(0, 3))
                    0: x = '0;
                    1: x = CFG_DATA_W'(1);
                    2: x = CFG_DATA_W'(32768);
                    default: x = CFG_DATA_W'(16'hFFFF);
                endcase
            end
        endcase
        apply_settings(a, b, n, 1'($urandom), x);
    endtask

    // Mix of steps and writes aimed around the play position and the pre-loop area.
    task automatic run_traffic(input int items);
        logic [IN_ADDR_W-1:0] addr;
        repeat (items) begin
            if ($urandom_range(0, 99) < 55) begin
                step_frames(1);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: addr = IN_ADDR_W'(play_pos + $urandom_range(0, 63));
                    4, 5, 6:    addr = IN_ADDR_W'(play_pos - $urandom_range(1, 300));
                    default:    addr = IN_ADDR_W'($urandom);
                endcase
                write_frame(addr, pick_sample(), pick_sample());
            end
        end
    endtask

    task automatic test_empty_memory();
        gap_pct   = 0;
        stall_pct = 0;
        step_frames(2);
    endtask

    task automatic load_range(input int first, input int last);
        for (int a = first; a <= last; a++) begin
            write_frame(IN_ADDR_W'(a), pick_sample(), pick_sample());
        end
    endtask

    // Fill the regions that the directed tests play through.
    task automatic load_memory();
        load_range(0, 47);
        load_range(90, 110);
        load_range(285, 300);
        load_range(500, 500);
        load_range(57900, 57900);
        load_range(950, 1099);
    endtask

    task automatic test_loop_wrap();
        gap_pct   = 20;
        stall_pct = 5;
        apply_settings(100, 110, CFG_DATA_W'(MEM_FRAMES), 1'b1, 4);
        write_frame(108, PEAK_LO, PEAK_HI);
        write_frame(97, PEAK_HI, PEAK_LO);
        step_frames(11);
        write_frame('1, PEAK_LO, PEAK_HI);
        write_frame('0, PEAK_HI, PEAK_LO);
    endtask

    task automatic test_pre_loop_edge();
        apply_settings(0, 4, CFG_DATA_W'(MEM_FRAMES), 1'b0, 6);
        step_frames(5);
    endtask

    task automatic test_bounds_normalisation();
        apply_settings(300, 290, CFG_DATA_W'(MEM_FRAMES), 1'b1, 3);
        step_frames(3);
        apply_settings(500, 500, CFG_DATA_W'(MEM_FRAMES), 1'b1, 2048);
        step_frames(1);
        apply_settings(60000, 60000, 62000, 1'b0, 16);
        step_frames(1);
        apply_settings(5, 5, 1, 1'b1, 2);
        step_frames(2);
        apply_settings(7, 7, 3000, 1'b1, 32768);
        step_frames(1);
    endtask

    task automatic test_short_crossfade();
        apply_settings(40, 43, CFG_DATA_W'(MEM_FRAMES), 1'b1, 1);
        step_frames(3);
        apply_settings(40, 43, CFG_DATA_W'(MEM_FRAMES), 1'b1, 0);
        step_frames(3);
    endtask

    task automatic test_random_traffic();
        int levels [4] = '{0, 10, 30, 60};
        for (int phase = 0; phase < 10; phase++) begin
            pick_settings();
            if (phase == 0) begin
                for (int i = int'(REG_XFADE_LEN) + 1; i < (1 << CFG_INDEX_W); i++) begin
                    write_reg(cfg_index_t'(i), CFG_DATA_W'($urandom));
                end
            end
            gap_pct   = levels[$urandom_range(0, 3)];
            stall_pct = levels[$urandom_range(0, 3)] / 3;
            run_traffic(110);
        end
    endtask

    task automatic test_steady_stream();
        apply_settings(1000, 1090, CFG_DATA_W'(MEM_FRAMES), 1'b1, 40);
        gap_pct   = 0;
        stall_pct = 0;
        run_traffic(150);
    endtask

    // Result side: random stall bursts
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 14);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: frame with none expected: L %0d R %0d fade %0b",
                             $realtime, m_data.left_out, m_data.right_out,
                             m_data.in_crossfade);
                end
            end else begin
                want_frame = expected_frames.pop_front();
                want_known = expected_known.pop_front();
                if (m_data.in_crossfade !== want_frame.in_crossfade
                        || (want_known && (m_data.left_out !== want_frame.left_out
                        || m_data.right_out !== want_frame.right_out))) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch: exp L %0d R %0d fade %0b, got L %0d R %0d fade %0b",
                                 $realtime, want_frame.left_out, want_frame.right_out,
                                 want_frame.in_crossfade, m_data.left_out,
                                 m_data.right_out, m_data.in_crossfade);
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_memory();
        load_memory();
        test_loop_wrap();
        test_pre_loop_edge();
        test_bounds_normalisation();
        test_short_crossfade();
        test_random_traffic();
        test_steady_stream();
        settle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: crossfade_loop_sample_reader.f
design/clsr_pkg.sv
design/clsr_ram.sv
design/clsr_ctrl.sv
design/clsr_datapath.sv
design/crossfade_loop_sample_reader.sv
tb/tb_crossfade_loop_sample_reader.sv
